FILE: sv/sll_pkg.sv
// Shared types, constants and controller/datapath interface structs for the linked list engine.
package sll_pkg;

  localparam int unsigned NODE_SLOTS_DEF = 64;
  localparam int unsigned LINK_W = 7;
  localparam int unsigned POS_W = 6;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OP_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 40;

  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(127);
  localparam logic [LINK_W-1:0] FIRST_DATA = LINK_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_CUR  = 2'd0,
    RD_FREE = 2'd1,
    RD_HEAD = 2'd2,
    RD_LINK = 2'd3
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_CUR  = 2'd0,
    WA_NODE = 2'd1,
    WA_FREE = 2'd2
  } wr_sel_t;

  typedef enum logic [1:0] {
    WD_LINK = 2'd0,
    WD_TMP  = 2'd1,
    WD_NODE = 2'd2
  } wd_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cur_from_rd;
    logic    node_from_rd;
    logic    tmp_from_rd;
    logic    cnt_inc;
    logic    wr_en;
    wr_sel_t wr_sel;
    wd_sel_t wd_sel;
    logic    val_wr;
    logic    init_wr;
    logic    out_load;
    status_t out_status;
    logic    out_has_data;
    logic    out_last;
  } sll_cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic in_pos_zero;
    op_t  op;
    logic rd_end;
    logic walk_done;
    logic walk_next_done;
    logic dump_limit;
    logic out_free;
    logic init_last;
  } sll_status_t;

endpackage

FILE: sv/static_linked_list_engine.sv
// Top level of the linked list engine: controller plus datapath on stream ports.
// After reset the engine builds the free chain in its link memory and accepts
// no word until that is done. Items are then taken one at a time. The link
// memory has one read port, so walking the list reads one link at a time.
// An item stalls wherever the output word register is not drained. Each
// insert and delete returns one word; a dump returns one word per element, or
// a single empty word when the list is empty. The last word of an item carries
// tlast, and tuser marks words that carry a list element.
module static_linked_list_engine
  import sll_pkg::*;
#(
  parameter int unsigned NODE_SLOTS = NODE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // operation, position, value
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // status, element, zero fill
  output logic                m_tuser,  // has_data
  output logic                m_tlast
);

  sll_cmd_t    cmd;
  sll_status_t st;

  sll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sll_dp #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: sv/sll_dp.sv
// Datapath: node link and value memories, walk registers and the output word register.
module sll_dp
  import sll_pkg::*;
#(
  parameter int unsigned NODE_SLOTS = NODE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  sll_cmd_t            cmd,
  output sll_status_t         st,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tuser,
  output logic                m_tlast
);

  localparam int unsigned AW = $clog2(NODE_SLOTS);
  localparam logic [AW-1:0] FREE_HEAD = AW'(0);
  localparam logic [AW-1:0] LIST_HEAD = AW'(1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(NODE_SLOTS - 1);
  localparam logic [POS_W-1:0] DUMP_LAST_CNT = POS_W'(NODE_SLOTS - 3);

  function automatic logic [LINK_W-1:0] reset_link(logic [AW-1:0] idx);
    logic [LINK_W-1:0] r;
    if (idx == FREE_HEAD) begin
      r = FIRST_DATA;
    end else if (idx == LIST_HEAD || idx == LAST_SLOT) begin
      r = END_MARK;
    end else begin
      r = LINK_W'(idx) + LINK_W'(1);
    end
    return r;
  endfunction

  logic [LINK_W-1:0]  link_mem [NODE_SLOTS];
  logic [VALUE_W-1:0] value_mem [NODE_SLOTS];

  op_t                op;
  logic [POS_W-1:0]   pos_m1;
  logic [VALUE_W-1:0] val;
  logic [LINK_W-1:0]  cur;
  logic [LINK_W-1:0]  node;
  logic [LINK_W-1:0]  tmp;
  logic [POS_W-1:0]   cnt;
  logic [AW-1:0]      init_idx;
  logic [LINK_W-1:0]  rd_link;
  logic [VALUE_W-1:0] rd_value;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0] out_element;

  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [LINK_W-1:0]  wr_data;
  logic               link_we;

  always_comb begin
    case (cmd.rd_sel)
      RD_CUR:  rd_addr = cur[AW-1:0];
      RD_FREE: rd_addr = FREE_HEAD;
      RD_HEAD: rd_addr = LIST_HEAD;
      RD_LINK: rd_addr = rd_link[AW-1:0];
      default: rd_addr = cur[AW-1:0];
    endcase
  end

  always_comb begin
    link_we = cmd.wr_en || cmd.init_wr;
    if (cmd.init_wr) begin
      wr_addr = init_idx;
      wr_data = reset_link(init_idx);
    end else begin
      case (cmd.wr_sel)
        WA_CUR:  wr_addr = cur[AW-1:0];
        WA_NODE: wr_addr = node[AW-1:0];
        WA_FREE: wr_addr = FREE_HEAD;
        default: wr_addr = cur[AW-1:0];
      endcase
      case (cmd.wd_sel)
        WD_LINK: wr_data = rd_link;
        WD_TMP:  wr_data = tmp;
        WD_NODE: wr_data = node;
        default: wr_data = rd_link;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.val_wr) begin
      value_mem[node[AW-1:0]] <= val;
    end
    if (cmd.rd_en) begin
      rd_link  <= link_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= op_t'(s_tdata[OP_W-1:0]);
      pos_m1 <= s_tdata[OP_W +: POS_W] - POS_W'(1);
      val    <= s_tdata[OP_W+POS_W +: VALUE_W];
      cur    <= LINK_W'(LIST_HEAD);
    end else if (cmd.cur_from_rd) begin
      cur <= rd_link;
    end
    if (cmd.node_from_rd) begin
      node <= rd_link;
    end
    if (cmd.tmp_from_rd) begin
      tmp <= rd_link;
    end
    if (cmd.out_load) begin
      out_status  <= cmd.out_status;
      out_element <= cmd.out_has_data ? rd_value : '0;
      m_tuser     <= cmd.out_has_data;
      m_tlast     <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      init_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + POS_W'(1);
      end
      if (cmd.init_wr) begin
        init_idx <= init_idx + AW'(1);
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(M_DATA_W - STATUS_W - VALUE_W)'(0), out_element, out_status};

  always_comb begin
    st.in_op          = op_t'(s_tdata[OP_W-1:0]);
    st.in_pos_zero    = (s_tdata[OP_W +: POS_W] == '0);
    st.op             = op;
    st.rd_end         = (rd_link == END_MARK);
    st.walk_done      = (cnt == pos_m1);
    st.walk_next_done = ((cnt + POS_W'(1)) == pos_m1);
    st.dump_limit     = (cnt == DUMP_LAST_CNT);
    st.out_free       = !m_tvalid || m_tready;
    st.init_last      = (init_idx == LAST_SLOT);
  end

endmodule

FILE: sv/sll_ctrl.sv
// Controller: sequences the link walk, relinking writes, dump and result words.
module sll_ctrl
  import sll_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  sll_status_t st,
  output sll_cmd_t    cmd
);

  typedef enum logic [18:0] {
    S_INIT       = 19'h00001,
    S_IDLE       = 19'h00002,
    S_WALK       = 19'h00004,
    S_WALK_DATA  = 19'h00008,
    S_INS_FREE   = 19'h00010,
    S_INS_NODE   = 19'h00020,
    S_INS_NFREE  = 19'h00040,
    S_INS_NCUR   = 19'h00080,
    S_INS_W0     = 19'h00100,
    S_INS_W1     = 19'h00200,
    S_DEL_RD     = 19'h00400,
    S_DEL_NODE   = 19'h00800,
    S_DEL_NN     = 19'h01000,
    S_DEL_FH     = 19'h02000,
    S_DEL_W      = 19'h04000,
    S_DUMP_HEAD  = 19'h08000,
    S_DUMP_FIRST = 19'h10000,
    S_DUMP_DATA  = 19'h20000,
    S_RESP       = 19'h40000
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t resp;
  status_t resp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      resp  <= ST_OK;
    end else begin
      state <= state_next;
      resp  <= resp_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    resp_next  = resp;
    cmd        = '0;
    cmd.rd_sel = RD_CUR;
    cmd.wr_sel = WA_CUR;
    cmd.wd_sel = WD_LINK;
    cmd.out_status = ST_OK;
    unique case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (st.init_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (st.in_op == OP_DUMP) begin
            state_next = S_DUMP_HEAD;
          end else if (st.in_op == OP_NONE || st.in_pos_zero) begin
            resp_next  = ST_BADPOS;
            state_next = S_RESP;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (st.walk_done) begin
          state_next = (st.op == OP_INSERT) ? S_INS_FREE : S_DEL_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_next = S_WALK_DATA;
        end
      end
      S_WALK_DATA: begin
        cmd.cur_from_rd = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (st.rd_end) begin
          resp_next  = ST_BADPOS;
          state_next = S_RESP;
        end else if (st.walk_next_done) begin
          state_next = (st.op == OP_INSERT) ? S_INS_FREE : S_DEL_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LINK;
        end
      end
      S_INS_FREE: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FREE;
        state_next = S_INS_NODE;
      end
      S_INS_NODE: begin
        if (st.rd_end) begin
          resp_next  = ST_FULL;
          state_next = S_RESP;
        end else begin
          cmd.node_from_rd = 1'b1;
          cmd.rd_en        = 1'b1;
          cmd.rd_sel       = RD_LINK;
          state_next       = S_INS_NFREE;
        end
      end
      S_INS_NFREE: begin
        cmd.tmp_from_rd = 1'b1;
        cmd.rd_en       = 1'b1;
        cmd.rd_sel      = RD_CUR;
        state_next      = S_INS_NCUR;
      end
      S_INS_NCUR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_NODE;
        cmd.wd_sel = WD_LINK;
        cmd.val_wr = 1'b1;
        state_next = S_INS_W0;
      end
      S_INS_W0: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_FREE;
        cmd.wd_sel = WD_TMP;
        state_next = S_INS_W1;
      end
      S_INS_W1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_CUR;
        cmd.wd_sel = WD_NODE;
        resp_next  = ST_OK;
        state_next = S_RESP;
      end
      S_DEL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CUR;
        state_next = S_DEL_NODE;
      end
      S_DEL_NODE: begin
        if (st.rd_end) begin
          resp_next  = ST_BADPOS;
          state_next = S_RESP;
        end else begin
          cmd.node_from_rd = 1'b1;
          cmd.rd_en        = 1'b1;
          cmd.rd_sel       = RD_LINK;
          state_next       = S_DEL_NN;
        end
      end
      S_DEL_NN: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_CUR;
        cmd.wd_sel = WD_LINK;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FREE;
        state_next = S_DEL_FH;
      end
      S_DEL_FH: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_NODE;
        cmd.wd_sel = WD_LINK;
        state_next = S_DEL_W;
      end
      S_DEL_W: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_FREE;
        cmd.wd_sel = WD_NODE;
        resp_next  = ST_OK;
        state_next = S_RESP;
      end
      S_DUMP_HEAD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HEAD;
        state_next = S_DUMP_FIRST;
      end
      S_DUMP_FIRST: begin
        if (st.rd_end) begin
          resp_next  = ST_OK;
          state_next = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LINK;
          state_next = S_DUMP_DATA;
        end
      end
      S_DUMP_DATA: begin
        if (st.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_status   = ST_OK;
          cmd.out_has_data = 1'b1;
          cmd.out_last     = st.rd_end || st.dump_limit;
          cmd.cnt_inc      = 1'b1;
          if (st.rd_end || st.dump_limit) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LINK;
          end
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
